// File: hdl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 16;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    op_t                       opcode;
    logic signed [DATA_W-1:0]  item_value;
    logic signed [DATA_W-1:0]  item_priority;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  out_value;
    status_t                   status;
  } result_t;

  // One stored entry of the queue.
  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  prio;
  } entry_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic    enq;
    logic    deq;
    entry_t  incoming;
  } cell_ctrl_t;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

endpackage

// File: hdl/spq_cell.sv
module spq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                 clk,
  input  spq_pkg::cell_ctrl_t  ctrl,
  input  logic [CNT_W-1:0]     count,
  input  spq_pkg::entry_t      left_entry,
  input  logic                 left_ge,
  input  spq_pkg::entry_t      right_entry,
  output spq_pkg::entry_t      entry,
  output logic                 ge
);

  spq_pkg::entry_t entry_next;
  logic            occupied;

  // The cell holds a live entry when its position lies below the fill count.
  assign occupied = CNT_W'(INDEX) < count;
  assign ge       = occupied && (entry.prio >= ctrl.incoming.prio);

  // The queue stays sorted, so ge is true on a prefix of the chain. The new
  // item lands in the first cell whose own ge is false; cells behind it move
  // one place towards the tail.
  always_comb begin
    entry_next = entry;
    priority if (ctrl.enq) begin
      if (ge) begin
        entry_next = entry;
      end else if (left_ge) begin
        entry_next = ctrl.incoming;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.deq) begin
      entry_next = right_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: hdl/stable_priority_queue.sv
// Stable max-first priority queue built as a chain of compare-and-shift cells.
//
// Command channel: cmd is taken at a rising edge where start is high and busy
// is low. busy is held low, so a command may be issued in every cycle. An
// enqueue stores item_value with item_priority; a dequeue removes the entry
// of highest priority, and among equal priorities the earliest one leaves
// first.
//
// Result channel: exactly one result item per command. done is high for one
// cycle, the cycle after the command was taken, with result valid alongside.
// Throughput is one command per cycle: every cell compares its priority with
// the incoming one in parallel, and the whole chain shifts in the same edge.
// The receiver cannot stall the block; results must be captured when done is
// high.
//
// Reset (rst, synchronous) empties the queue by clearing the fill count; the
// cell contents are left as they are and are never read before being written.
module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::cmd_t     cmd,
  output logic              done,
  output spq_pkg::result_t  result
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                accept;
  logic                is_empty;
  logic                is_full;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::result_t    result_next;

  spq_pkg::entry_t     entries [CAPACITY];
  logic                ges     [CAPACITY];

  // The block never holds a command off: busy is tied low.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(CAPACITY));

  // The chain only moves for operations that succeed; a refused enqueue or an
  // empty dequeue leaves every cell untouched.
  always_comb begin
    ctrl.enq      = accept && (cmd.opcode == spq_pkg::OP_ENQUEUE) && !is_full;
    ctrl.deq      = accept && (cmd.opcode == spq_pkg::OP_DEQUEUE) && !is_empty;
    ctrl.incoming.value = cmd.item_value;
    ctrl.incoming.prio  = cmd.item_priority;
  end

  always_comb begin
    count_next = count;
    priority if (ctrl.enq) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  // The head cell always holds the entry that leaves next, so a dequeue reads
  // its value directly.
  always_comb begin
    unique case (cmd.opcode)
      spq_pkg::OP_DEQUEUE: begin
        if (is_empty) begin
          result_next.out_value = spq_pkg::EMPTY_VALUE;
          result_next.status    = spq_pkg::ST_EMPTY;
        end else begin
          result_next.out_value = entries[0].value;
          result_next.status    = spq_pkg::ST_DEQUEUED;
        end
      end
      default: begin
        result_next.out_value = '0;
        result_next.status    = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // The head cell sees a virtual neighbour whose ge is true, so an item that
  // outranks every stored entry goes straight into the head. The tail cell's
  // right neighbour is itself.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    logic            left_ge;
    spq_pkg::entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_entry = ctrl.incoming;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_ge    = ges[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left_entry  (left_entry),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .ge          (ges[i])
    );
  end

endmodule

// File: hdl/spq_checker.sv
module spq_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  spq_pkg::cmd_t     cmd,
  input  logic              done,
  input  spq_pkg::result_t  result
);

  // Every taken command yields a result in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (!rst && start && !busy) |=> done)
    else $error("taken command gave no result");

  // No result appears without a command having been taken.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a command");

  // A dequeue reports either a value or an empty queue, never an enqueue code.
  a_deq_status: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd.opcode) == spq_pkg::OP_DEQUEUE) |->
      (result.status == spq_pkg::ST_DEQUEUED || result.status == spq_pkg::ST_EMPTY))
    else $error("dequeue gave an enqueue status");

  // Enqueue results carry zero, an empty dequeue carries all ones.
  a_fixed_values: assert property (@(posedge clk) disable iff (rst)
    done |->
      ((result.status == spq_pkg::ST_EMPTY && result.out_value == spq_pkg::EMPTY_VALUE) ||
       ((result.status == spq_pkg::ST_ENQUEUED || result.status == spq_pkg::ST_FULL) &&
        result.out_value == '0) ||
       result.status == spq_pkg::ST_DEQUEUED))
    else $error("result value does not match its status");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);
